### hw/rtl/assert_macros.svh
// assertion macros used by the glob matcher core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// condition holds at every edge outside reset
`define WGM_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("wgm assertion failed");
// consequence in the same cycle
`define WGM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wgm assertion failed");
// consequence in the next cycle
`define WGM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wgm assertion failed");
`else
`define WGM_ASSERT_ALWAYS(name, clk, rst, cond)
`define WGM_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define WGM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/wgm_pkg.sv
// types, constants and helpers of the glob matcher
package wgm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 32;

   localparam logic [7:0] SYM_STAR     = 8'd42;
   localparam logic [7:0] SYM_QUESTION = 8'd63;
   localparam logic [7:0] SYM_LOWER_A  = 8'd97;
   localparam logic [7:0] SYM_LOWER_Z  = 8'd122;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_TEXT   = 2'd2,
      FUNC_END    = 2'd3
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] symbol;
   } item_type;

   typedef struct packed {
      logic overflow;
      logic matched;
   } result_type;

   // ascii lower case to upper when folding is on
   function automatic logic [7:0] fold_case(input logic [7:0] c, input logic fold_en);
      logic [7:0] r;
      r = c;
      if (fold_en && c >= SYM_LOWER_A && c <= SYM_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

### hw/rtl/wgm_in_reg.sv
// input register stage holding one request beat
module wgm_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  wgm_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output wgm_pkg::item_type item
);

   logic              valid_ff, valid_in;
   wgm_pkg::item_type item_ff, item_in;
   logic              load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### hw/rtl/wgm_core.sv
// pattern store and bit-parallel glob automaton
`include "assert_macros.svh"
module wgm_core #(
   parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                ignore_case,
   input  logic                item_valid,
   input  wgm_pkg::item_type   item,
   output logic                res_valid,
   output wgm_pkg::result_type result
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int POS_W = MAX_PATTERN + 1;

   logic [7:0]       store_ff [MAX_PATTERN];
   logic [LEN_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] active_ff, active_in;
   logic [POS_W-1:0] rearm_ff, rearm_in;
   logic             dropped_ff, dropped_in;

   logic             full;
   logic             store_wr;
   logic [LEN_W:0]   len_plus;
   logic [7:0]       fsym;
   logic [MAX_PATTERN-1:0] in_pat, is_star, stay, hit, prop;
   logic [POS_W-1:0] next_raw, step_mask, next_closed, above_len;
   logic [POS_W:0]   add_a, add_b, add_s, carries;
   logic             clear_taken;
   logic             clear_state;

   assign full     = (len_ff == LEN_W'(MAX_PATTERN));
   assign len_plus = {1'b0, len_ff} + 1'b1;
   assign fsym     = wgm_pkg::fold_case(item.symbol, ignore_case);

   // per-position compare against the incoming text byte
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         in_pat[i]  = LEN_W'(i) < len_ff;
         is_star[i] = store_ff[i] == wgm_pkg::SYM_STAR;
         prop[i]    = in_pat[i] && is_star[i];
         stay[i]    = prop[i] && active_ff[i];
         hit[i]     = in_pat[i] && active_ff[i] && !is_star[i]
                      && (store_ff[i] == wgm_pkg::SYM_QUESTION
                          || wgm_pkg::fold_case(store_ff[i], ignore_case) == fsym);
      end
      for (int j = 0; j < POS_W; j++) begin
         above_len[j] = LEN_W'(j) > len_ff;
      end
   end

   assign next_raw  = {1'b0, stay} | {hit, 1'b0};
   assign step_mask = {prop, 1'b0};

   // star closure as a carry chain: generate on active, propagate past stars
   assign add_a       = {1'b0, next_raw | step_mask};
   assign add_b       = {1'b0, next_raw};
   assign add_s       = add_a + add_b;
   assign carries     = add_s ^ add_a ^ add_b;
   assign next_closed = carries[POS_W:1];

   always_comb begin
      len_in     = len_ff;
      dropped_in = dropped_ff;
      rearm_in   = rearm_ff;
      active_in  = active_ff;
      store_wr   = 1'b0;
      res_valid  = 1'b0;
      if (item_valid) begin
         unique case (item.func)
            wgm_pkg::FUNC_CLEAR: begin
               len_in     = '0;
               dropped_in = 1'b0;
               rearm_in   = POS_W'(1);
               active_in  = POS_W'(1);
            end
            wgm_pkg::FUNC_APPEND: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  store_wr = 1'b1;
                  len_in   = len_plus[LEN_W-1:0];
                  if (item.symbol == wgm_pkg::SYM_STAR && rearm_ff[len_ff]) begin
                     rearm_in = rearm_ff | (POS_W'(1) << len_plus);
                  end
               end
               active_in = rearm_in;
            end
            wgm_pkg::FUNC_TEXT: begin
               active_in = next_closed;
            end
            wgm_pkg::FUNC_END: begin
               res_valid = 1'b1;
               active_in = rearm_ff;
            end
         endcase
      end
   end

   assign result.matched  = active_ff[len_ff];
   assign result.overflow = dropped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         dropped_ff <= 1'b0;
         rearm_ff   <= POS_W'(1);
         active_ff  <= POS_W'(1);
      end else begin
         len_ff     <= len_in;
         dropped_ff <= dropped_in;
         rearm_ff   <= rearm_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[len_ff[IDX_W-1:0]] <= item.symbol;
      end
   end

   // clear beat taken, and the state it leaves behind
   assign clear_taken = item_valid && item.func == wgm_pkg::FUNC_CLEAR;
   assign clear_state = len_ff == '0 && !dropped_ff && active_ff == POS_W'(1);

   `WGM_ASSERT_ALWAYS(a_len_bound, clock, reset, len_ff <= LEN_W'(MAX_PATTERN))
   `WGM_ASSERT_IMPLY(a_drop_full, clock, reset, dropped_ff, full)
   `WGM_ASSERT_ALWAYS(a_no_stray, clock, reset, ((active_ff | rearm_ff) & above_len) == '0)
   `WGM_ASSERT_NEXT(a_clear, clock, reset, clear_taken, clear_state)

endmodule

### hw/rtl/wgm_out_reg.sv
// result register driving the response channel
module wgm_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  wgm_pkg::result_type result,
   output logic                space,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output wgm_pkg::result_type rsp_result
);

   logic                valid_ff, valid_in;
   wgm_pkg::result_type data_ff, data_in;

   assign space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = data_ff;

endmodule

### hw/rtl/wildcard_glob_matcher_top.sv
// top level of the streaming glob matcher
// glob matcher: '*' matches any run of bytes including none, '?' exactly one byte. load a
// pattern with append beats (tuser 1) after a clear beat (tuser 0), stream text bytes with
// tuser 2, and close the text with tuser 3, which returns one beat with matched and overflow
// and rearms for the next text against the same pattern. appends beyond MAX_PATTERN bytes are
// dropped and flagged as overflow until the next clear. one beat is taken every cycle unless
// an end-of-text beat waits; a request beat is worked on while it sits in the input register,
// and its result goes through the result register to rsp. the per-cycle limit is set by the
// automaton update: a byte compare at every pattern position followed by one MAX_PATTERN+1 bit
// carry chain for the star closure. end-of-text beats wait only while the result register is
// full and not being drained. csr writes set ignore_case, folding ascii a-z to upper case
module wildcard_glob_matcher_top #(
   parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] func
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] matched, [1] overflow, [7:2] zero
   // configuration write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // ignore_case
);

   wgm_pkg::item_type   req_item;
   wgm_pkg::item_type   item;
   wgm_pkg::result_type result;
   wgm_pkg::result_type rsp_result;
   logic                item_valid;
   logic                take;
   logic                res_valid;
   logic                out_space;
   logic                ic_ff, ic_in;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign ic_in     = (csr_valid && csr_ready) ? csr_data : ic_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff <= 1'b0;
      end else begin
         ic_ff <= ic_in;
      end
   end

   // unpack the request beat
   assign req_item.func   = wgm_pkg::func_type'(req_tuser);
   assign req_item.symbol = req_tdata;

   // a held beat moves on unless it is an end-of-text with nowhere to put the result
   assign take = item_valid && (item.func != wgm_pkg::FUNC_END || out_space);

   wgm_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // automaton sees only beats that are moving on
   wgm_core #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .ignore_case (ic_ff),
      .item_valid  (take),
      .item        (item),
      .res_valid   (res_valid),
      .result      (result)
   );

   wgm_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .result     (result),
      .space      (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   // pack the result beat, matched in the lowest bit
   assign rsp_tdata = {6'b000000, rsp_result.overflow, rsp_result.matched};

endmodule
